// ===== src/hex_record_parser_unit_assert.svh =====
// Assertion macros for the parser RTL.
`ifndef HEX_RECORD_PARSER_UNIT_ASSERT_SVH
`define HEX_RECORD_PARSER_UNIT_ASSERT_SVH

// Concurrent check on clk, disabled while rst_n is low.
`define HRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also active during reset.
`define HRP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/hrp_pkg.sv =====
package hrp_pkg;

    localparam logic [7:0] COLON_CHAR = 8'h3A;
    localparam logic [3:0] ALPHA_ADJ  = 4'h9;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_GOOD = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    typedef enum logic [6:0] {
        PH_HUNT    = 7'b0000001,
        PH_COUNT   = 7'b0000010,
        PH_ADDR_HI = 7'b0000100,
        PH_ADDR_LO = 7'b0001000,
        PH_TYPE    = 7'b0010000,
        PH_DATA    = 7'b0100000,
        PH_CHECK   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [7:0]  byte_index;
        logic [15:0] byte_address;
        logic [7:0]  rec_kind;
        logic [7:0]  data_length;
        logic        last;
    } result_t;

    // Hex digit value, no validity check: letters have bit 6 set.
    function automatic logic [3:0] digit_of(input logic [7:0] c);
        logic [3:0] v;
        if (c[6])
        begin
            v = c[3:0] + ALPHA_ADJ;
        end
        else
        begin
            v = c[3:0];
        end
        return v;
    endfunction

endpackage

// ===== src/hex_record_parser_unit.sv =====
// Channel | Handshake           | Payload per beat
// --------+---------------------+----------------------------------------------
// in      | in_valid / in_stall | character
// out     | out_valid/out_stall | kind, byte_value, byte_index, byte_address,
//         |                     | rec_kind, data_length, last
//
// One character per cycle sustained while out_stall is low; the character and its result are each registered.
// Throughput is set by the single parse step between the input and result registers.
// Reset (rst_n low, async) returns the parser to colon hunting with an empty pipe.
// A stalled result holds the result register; the input register then fills,
// and in_stall rises only while that input register holds an unparsed character.
`include "hex_record_parser_unit_assert.svh"

module hex_record_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  character,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  byte_value,
    output logic [7:0]  byte_index,
    output logic [15:0] byte_address,
    output logic [7:0]  rec_kind,
    output logic [7:0]  data_length,
    output logic        last
);
    import hrp_pkg::*;

    // input register
    logic       in_full_reg, in_full_next;
    logic [7:0] char_reg;

    logic       advance;
    logic       in_accept;
    logic       out_take;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    // parse step fires when a character is held and the result slot frees up
    assign advance   = in_full_reg && (!out_valid || !out_stall);
    assign in_stall  = in_full_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid && !out_stall;

    always_comb
    begin
        priority if (in_accept)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end
        else
        begin
            in_full_next = in_full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            char_reg <= character;
        end
    end

    hrp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .char_in   (char_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    hrp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .out_take  (out_take),
        .res_valid (res_valid),
        .res       (res),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign kind         = out_res.kind;
    assign byte_value   = out_res.byte_value;
    assign byte_index   = out_res.byte_index;
    assign byte_address = out_res.byte_address;
    assign rec_kind     = out_res.rec_kind;
    assign data_length  = out_res.data_length;
    assign last         = out_res.last;

    // held character must survive a blocked parse step
    `HRP_ASSERT(a_in_hold, in_full_reg && !advance |=> in_full_reg && $stable(char_reg), "input register lost a held character")
    // status beats close records, data beats never do
    `HRP_ASSERT(a_last_kind, out_valid |-> (last == (kind != KIND_DATA)), "last flag disagrees with kind")
    // status beats carry zero value and index
    `HRP_ASSERT(a_status_zero, out_valid && last |-> byte_value == 8'd0 && byte_index == 8'd0, "status beat carries data")
    // backpressure only with a full input register
    `HRP_ASSERT_ALWAYS(a_stall_full, in_stall |-> in_full_reg, "stall raised with empty input register")

endmodule

// ===== src/hrp_core.sv =====
module hrp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [7:0]        char_in,
    output logic              res_valid,
    output hrp_pkg::result_t  res
);
    import hrp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        second_reg, second_next;
    logic [3:0]  high_reg, high_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  length_reg, length_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  count_reg, count_next;

    logic [3:0]  digit;
    logic [7:0]  byte_val;
    logic [7:0]  count_inc;
    logic [7:0]  expect_sum;

    assign digit      = digit_of(char_in);
    assign byte_val   = {high_reg, digit};
    assign count_inc  = count_reg + 8'd1;
    assign expect_sum = 8'd0 - sum_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        second_next = second_reg;
        high_next   = high_reg;
        sum_next    = sum_reg;
        length_next = length_reg;
        addr_next   = addr_reg;
        type_next   = type_reg;
        count_next  = count_reg;
        res_valid   = 1'b0;
        res.kind         = KIND_DATA;
        res.byte_value   = 8'd0;
        res.byte_index   = 8'd0;
        res.byte_address = addr_reg;
        res.rec_kind     = type_reg;
        res.data_length  = length_reg;
        res.last         = 1'b0;

        if (phase_reg == PH_HUNT)
        begin
            if (char_in == COLON_CHAR)
            begin
                phase_next  = PH_COUNT;
                second_next = 1'b0;
                sum_next    = 8'd0;
                count_next  = 8'd0;
            end
        end
        else if (!second_reg)
        begin
            high_next   = digit;
            second_next = 1'b1;
        end
        else
        begin
            second_next = 1'b0;
            sum_next    = sum_reg + byte_val;
            unique case (phase_reg)
                PH_COUNT:
                begin
                    length_next = byte_val;
                    phase_next  = PH_ADDR_HI;
                end
                PH_ADDR_HI:
                begin
                    addr_next  = {byte_val, addr_reg[7:0]};
                    phase_next = PH_ADDR_LO;
                end
                PH_ADDR_LO:
                begin
                    addr_next  = {addr_reg[15:8], byte_val};
                    phase_next = PH_TYPE;
                end
                PH_TYPE:
                begin
                    type_next  = byte_val;
                    phase_next = (length_reg == 8'd0) ? PH_CHECK : PH_DATA;
                end
                PH_DATA:
                begin
                    res_valid        = 1'b1;
                    res.byte_value   = byte_val;
                    res.byte_index   = count_reg;
                    res.byte_address = addr_reg + {8'd0, count_reg};
                    count_next       = count_inc;
                    if (count_inc == length_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    res_valid  = 1'b1;
                    res.kind   = (expect_sum == byte_val) ? KIND_GOOD : KIND_BAD;
                    res.last   = 1'b1;
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            second_reg <= 1'b0;
            high_reg   <= 4'd0;
            sum_reg    <= 8'd0;
            length_reg <= 8'd0;
            addr_reg   <= 16'd0;
            type_reg   <= 8'd0;
            count_reg  <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            second_reg <= second_next;
            high_reg   <= high_next;
            sum_reg    <= sum_next;
            length_reg <= length_next;
            addr_reg   <= addr_next;
            type_reg   <= type_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/hrp_out_stage.sv =====
module hrp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              out_take,
    input  logic              res_valid,
    input  hrp_pkg::result_t  res,
    output logic              out_valid,
    output hrp_pkg::result_t  out_res
);
    import hrp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // advance only fires when the held beat is empty or being taken;
    // a beat taken with no parse step behind it leaves the slot empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= res_valid;
        end
        else if (out_take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== test/hex_record_parser_unit_tb.sv =====
`timescale 1ns / 100ps

// Character stream in, decoded data bytes and record status beats out.
// Each test below drives characters through one sender task.
// The predictor mirrors the parser state and queues the beats it expects.
// One monitor process compares every accepted output beat with the oldest
// queued beat.
module hex_record_parser_unit_tb;
    import hrp_pkg::*;

    localparam int         TRAFFIC_CHARS = 300;
    localparam int         MAX_REPORTS   = 10;
    localparam int         HOLD_CYCLES   = 80;
    localparam logic [7:0] ZERO_CHAR     = "0";

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  character = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [7:0]  byte_index;
    logic [15:0] byte_address;
    logic [7:0]  rec_kind;
    logic [7:0]  data_length;
    logic        last;

    hex_record_parser_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .character    (character),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .byte_value   (byte_value),
        .byte_index   (byte_index),
        .byte_address (byte_address),
        .rec_kind     (rec_kind),
        .data_length  (data_length),
        .last         (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Idle mix, in percent of cycles
    int idle_pct  = 0;
    int stall_pct = 0;
    // Remaining cycles of a forced output hold-off
    int hold_left = 0;

    int chars_sent  = 0;
    int data_seen   = 0;
    int good_seen   = 0;
    int bad_seen    = 0;
    int error_count = 0;

    // ------------------------------------------------------------------
    // Parser predictor: a private copy of the record state
    // ------------------------------------------------------------------
    phase_t      rx_phase       = PH_HUNT;
    logic        rx_low_next    = 1'b0;
    logic [3:0]  rx_high_nibble = 4'h0;
    logic [7:0]  rx_sum         = 8'h00;
    logic [7:0]  rx_len         = 8'h00;
    logic [15:0] rx_addr        = 16'h0000;
    logic [7:0]  rx_type        = 8'h00;
    logic [7:0]  rx_count       = 8'h00;
    result_t     pending_results[$];

    // Any character counts as a digit; letters have bit 6 set.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] adj;
        adj = c[3:0] + 4'd9;
        return c[6] ? adj : c[3:0];
    endfunction

    function automatic void track_char(input logic [7:0] c);
        logic [7:0] b;
        result_t    r;
        if (rx_phase == PH_HUNT)
        begin
            if (c == COLON_CHAR)
            begin
                rx_phase    = PH_COUNT;
                rx_low_next = 1'b0;
                rx_sum      = 8'h00;
                rx_count    = 8'h00;
            end
            return;
        end
        if (!rx_low_next)
        begin
            rx_high_nibble = nibble_of(c);
            rx_low_next    = 1'b1;
            return;
        end
        rx_low_next = 1'b0;
        b = {rx_high_nibble, nibble_of(c)};
        r = '0;
        case (rx_phase)
            PH_COUNT:
            begin
                rx_len   = b;
                rx_sum   = rx_sum + b;
                rx_phase = PH_ADDR_HI;
            end
            PH_ADDR_HI:
            begin
                rx_addr[15:8] = b;
                rx_sum        = rx_sum + b;
                rx_phase      = PH_ADDR_LO;
            end
            PH_ADDR_LO:
            begin
                rx_addr[7:0] = b;
                rx_sum       = rx_sum + b;
                rx_phase     = PH_TYPE;
            end
            PH_TYPE:
            begin
                rx_type  = b;
                rx_sum   = rx_sum + b;
                // zero byte count goes straight to the checksum
                rx_phase = (rx_len == 8'h00) ? PH_CHECK : PH_DATA;
            end
            PH_DATA:
            begin
                rx_sum         = rx_sum + b;
                r.kind         = KIND_DATA;
                r.byte_value   = b;
                r.byte_index   = rx_count;
                r.byte_address = rx_addr + 16'(rx_count);
                r.rec_kind     = rx_type;
                r.data_length  = rx_len;
                r.last         = 1'b0;
                pending_results.push_back(r);
                rx_count = rx_count + 8'd1;
                if (rx_count == rx_len)
                begin
                    rx_phase = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                r.kind         = (8'(-rx_sum) == b) ? KIND_GOOD : KIND_BAD;
                r.byte_address = rx_addr;
                r.rec_kind     = rx_type;
                r.data_length  = rx_len;
                r.last         = 1'b1;
                pending_results.push_back(r);
                rx_sum   = rx_sum + b;
                rx_phase = PH_HUNT;
            end
            default:
            begin
                rx_phase = PH_HUNT;
            end
        endcase
    endfunction

    function automatic string describe(input result_t r);
        return $sformatf("kind=%0d value=%02h index=%0d addr=%04h type=%02h len=%0d last=%0b",
                         r.kind, r.byte_value, r.byte_index, r.byte_address,
                         r.rec_kind, r.data_length, r.last);
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: random stall, or a long forced hold-off when asked
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Output checker: one accepted beat against the oldest expectation
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {kind, byte_value, byte_index, byte_address, rec_kind, data_length, last};
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected beat: %s", $realtime, describe(got));
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch", $realtime);
                        $display("  expected %s", describe(want));
                        $display("  actual   %s", describe(got));
                    end
                end
                else if (want.kind == KIND_DATA)
                begin
                    data_seen++;
                end
                else if (want.kind == KIND_GOOD)
                begin
                    good_seen++;
                end
                else
                begin
                    bad_seen++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // One input beat; random idle cycles go in front of it. This task only
    // lowers in_valid inside a gap, so back-to-back beats keep it high.
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        character <= c;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        track_char(c);
        chars_sent++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] letter_base;
        letter_base = ($urandom_range(1) == 1) ? "A" : "a";
        return (n < 4'd10) ? ZERO_CHAR + 8'(n) : letter_base + 8'(n - 4'd10);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        send_char(hex_char(b[7:4]));
        send_char(hex_char(b[3:0]));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i]);
        end
    endtask

    // Well-formed record with random data; corrupt spoils the checksum.
    task automatic send_record(input logic [7:0] len, input logic [15:0] addr,
                               input logic [7:0] rtype, input bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        sum = len + addr[15:8] + addr[7:0] + rtype;
        send_char(COLON_CHAR);
        send_byte(len);
        send_byte(addr[15:8]);
        send_byte(addr[7:0]);
        send_byte(rtype);
        for (int i = 0; i < len; i++)
        begin
            b   = 8'($urandom);
            sum = sum + b;
            send_byte(b);
        end
        b = -sum;
        if (corrupt)
        begin
            b = b + 8'($urandom_range(1, 255));
        end
        send_byte(b);
    endtask

    // Feed zero digits until the parser is back to hunting for a colon.
    task automatic flush_record;
        while (rx_phase != PH_HUNT)
        begin
            send_char(ZERO_CHAR);
        end
    endtask

    // Stop offering beats until every expected result is out.
    task automatic wait_for_drain;
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Extremes and corner records: junk before the colon, zero byte count
    // with lowercase digits, colons taken as digits, a bad checksum.
    task automatic test_directed_records;
        idle_pct  = 0;
        stall_pct = 0;
        send_char(8'h00);
        send_char(8'hFF);
        send_text(":00FFff0101");       // zero length, checksum good
        send_text(":01::0000FF00");     // address AA00, one data byte, checksum bad
        wait_for_drain;
    endtask

    // Long output hold-off with the sender pushing at full rate, so the
    // result and input registers fill and in_stall has to rise.
    task automatic test_backpressure;
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = HOLD_CYCLES;
        send_record(8'd24, 16'h1234, 8'h00, 1'b0);
        wait_for_drain;
    endtask

    // Mostly well-formed records with random content; the rest are broken
    // records (random raw characters after the header start) and line noise.
    task automatic test_traffic(input int sender_idle, input int recv_stall);
        int         stop_at;
        int         roll;
        logic [7:0] len;
        logic [15:0] addr;
        logic [7:0] rtype;
        idle_pct  = sender_idle;
        stall_pct = recv_stall;
        stop_at   = chars_sent + TRAFFIC_CHARS;
        while (chars_sent < stop_at)
        begin
            roll = $urandom_range(99);
            if (roll < 75)
            begin
                // a rare long record, otherwise short
                len   = ($urandom_range(39) == 0) ? 8'($urandom_range(200, 255))
                                                  : 8'($urandom_range(16));
                // some addresses near the top so data addresses wrap
                addr  = ($urandom_range(3) == 0) ? 16'hFFFF - 16'($urandom_range(20))
                                                 : 16'($urandom);
                rtype = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(5));
                send_record(len, addr, rtype, $urandom_range(4) == 0);
            end
            else if (roll < 88)
            begin
                send_char(COLON_CHAR);
                send_byte(8'($urandom_range(8)));
                repeat ($urandom_range(1, 6))
                begin
                    send_char(8'($urandom));
                end
                flush_record;
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    send_char(8'($urandom));
                end
                flush_record;
            end
        end
        wait_for_drain;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_records;
        test_backpressure;
        test_traffic(0, 0);
        test_traffic(71, 0);
        test_traffic(0, 71);
        test_traffic(24, 24);

        // Give stray beats time to show up.
        repeat (8) @(posedge clk);
        error_count += pending_results.size();
        $display("%0d characters sent: %0d data bytes, %0d good and %0d bad checksum beats",
                 chars_sent, data_seen, good_seen, bad_seen);
        $display("covered corner records, broken and noisy streams, a long hold-off, four idle mixes");
        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Timeout
    initial
    begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/hrp_pkg.sv
src/hrp_core.sv
src/hrp_out_stage.sv
src/hex_record_parser_unit.sv
test/hex_record_parser_unit_tb.sv
